### rtl/distance_filter_classifier_defines.svh
// Assertion macros shared by the range classifier.
`ifndef DISTANCE_FILTER_CLASSIFIER_DEFINES_SVH
`define DISTANCE_FILTER_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define DFC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("distance_filter_classifier: assertion failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define DFC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("distance_filter_classifier: assertion failed");

`endif

### rtl/dfc_pkg.sv
`timescale 1ns / 1ps

package dfc_pkg;

	// Window and field widths.
	localparam int WINDOW   = 3;
	localparam int DIST_W   = 16;
	localparam int CM_W     = 10;
	localparam int RUN_W    = 8;
	localparam int CMD_W    = 3;
	localparam int FILL_W   = $clog2(WINDOW + 1);
	localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int SUM_W    = $clog2(WINDOW * ((1 << CM_W) - 1) + 1);
	localparam int DIV_SHIFT = 16;
	localparam int RECIP_W  = DIV_SHIFT + 1;
	localparam int RECIP_IN_W = 4;
	localparam int PROD_W   = SUM_W + RECIP_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 10;
	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_STOP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DECEL    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAINTAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAULT    = 3'd4;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_STOP     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DECEL    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MAINTAIN = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ACCEL    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FAULT    = 3'd4;

	typedef struct packed {
		logic              timed_out;
		logic [DIST_W-1:0] range_cm;
	} sample_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [CM_W-1:0]  mean_cm;
		logic             fault_flag;
	} result_t;

	// Microcode: datapath operation, jump condition, jump target, end of program.
	typedef enum logic [2:0] {
		OP_FETCH,
		OP_UPDATE,
		OP_ACC,
		OP_DIV,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		JC_NEVER,
		JC_NO_INPUT,
		JC_TIMED_OUT,
		JC_ACC_MORE,
		JC_OUT_BUSY
	} jcond_t;

	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd0;
	localparam logic [STEP_W-1:0] STEP_UPDATE = 3'd1;
	localparam logic [STEP_W-1:0] STEP_ACC    = 3'd2;
	localparam logic [STEP_W-1:0] STEP_DIV    = 3'd3;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd4;

	typedef struct packed {
		op_t               op;
		jcond_t            cond;
		logic [STEP_W-1:0] target;
		logic              last;
	} uword_t;

	// The program store.
	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
		uword_t w;
		case (step)
			STEP_FETCH:  w = '{op: OP_FETCH,  cond: JC_NO_INPUT,  target: STEP_FETCH,  last: 1'b0};
			STEP_UPDATE: w = '{op: OP_UPDATE, cond: JC_TIMED_OUT, target: STEP_EMIT,   last: 1'b0};
			STEP_ACC:    w = '{op: OP_ACC,    cond: JC_ACC_MORE,  target: STEP_ACC,    last: 1'b0};
			STEP_DIV:    w = '{op: OP_DIV,    cond: JC_NEVER,     target: STEP_FETCH,  last: 1'b0};
			STEP_EMIT:   w = '{op: OP_EMIT,   cond: JC_OUT_BUSY,  target: STEP_EMIT,   last: 1'b1};
			default:     w = '{op: OP_FETCH,  cond: JC_NEVER,     target: STEP_FETCH,  last: 1'b1};
		endcase
		return w;
	endfunction

	// Reciprocals ceil(2^16 / n), exact for floor division of any window sum.
	// The argument is wide enough for the largest window that the table covers.
	function automatic logic [RECIP_W-1:0] recip(input logic [RECIP_IN_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd1:    r = 17'd65536;
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd5:    r = 17'd13108;
			4'd6:    r = 17'd10923;
			4'd7:    r = 17'd9363;
			4'd8:    r = 17'd8192;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

### rtl/distance_filter_classifier.sv
`timescale 1ns / 1ps
// Range classifier: each sample word on the sample channel is either a distance or a timeout.
// A distance is clamped, kept in a three-entry ring, and the floor average of the samples
// held so far is compared with the stop, decelerate and maintain thresholds to give a
// command word. Timeouts count up a run (saturating at 255); once the run reaches the fault
// threshold a sensor-fault word with distance 0 is sent, and below it a timeout sends no
// word. A small microcoded sequencer runs each sample: after acceptance a distance goes
// through the update step, the summing step (one held sample per cycle, n samples held,
// 1 to 3), the divide step and the emit step, which loads the output register; a timeout
// goes from update straight to emit. Then the sequencer returns to fetch for the next
// sample. While the output register holds a word not yet taken, an emit step with a word
// to send waits and the sample channel waits with it. One sample is handled at a time.
// Configuration writes are always taken and should be made while the block is idle.
`include "distance_filter_classifier_defines.svh"

module distance_filter_classifier (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	input  dfc_pkg::sample_t                 sample,
	output logic                             result_valid,
	input  logic                             result_ready,
	output dfc_pkg::result_t                 result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dfc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dfc_pkg::CFG_DAT_W-1:0]    cfg_data
);

	// Configuration registers.
	logic [dfc_pkg::CM_W-1:0]  stop_q, decel_q, maintain_q, clamp_q;
	logic [dfc_pkg::RUN_W-1:0] fault_q;

	// Filter state.
	logic [dfc_pkg::CM_W-1:0]   ring_q [dfc_pkg::WINDOW];
	logic [dfc_pkg::FILL_W-1:0] fill_q;
	logic [dfc_pkg::IDX_W-1:0]  slot_q;
	logic [dfc_pkg::RUN_W-1:0]  run_q;

	// Sequencer and datapath registers.
	logic [dfc_pkg::STEP_W-1:0] step_q, step_next;
	dfc_pkg::uword_t            uw;
	dfc_pkg::sample_t           in_q;
	logic [dfc_pkg::IDX_W-1:0]  acc_idx_q;
	logic [dfc_pkg::SUM_W-1:0]  sum_q;
	logic [dfc_pkg::CM_W-1:0]   avg_q;
	dfc_pkg::result_t           result_q;
	logic                       result_valid_q;

	logic                       jump;
	logic                       fault_now;
	logic                       has_result;
	logic                       out_busy;
	logic                       acc_more;
	logic [dfc_pkg::CM_W-1:0]   clamped;
	logic [dfc_pkg::PROD_W-1:0] product;
	logic [dfc_pkg::CMD_W-1:0]  cmd_class;

	assign uw = dfc_pkg::ucode_rom(step_q);

	// Status seen by the jump conditions and the emit step.
	assign fault_now  = (run_q >= fault_q);
	assign has_result = fault_now || !in_q.timed_out;
	assign out_busy   = result_valid_q && !result_ready;
	assign acc_more   = (dfc_pkg::FILL_W'(acc_idx_q) + 1'b1) < fill_q;

	// Next step: a taken condition jumps to the target, otherwise step on or go home.
	always_comb begin
		case (uw.cond)
			dfc_pkg::JC_NO_INPUT:  jump = !sample_valid;
			dfc_pkg::JC_TIMED_OUT: jump = in_q.timed_out;
			dfc_pkg::JC_ACC_MORE:  jump = acc_more;
			dfc_pkg::JC_OUT_BUSY:  jump = has_result && out_busy;
			default:               jump = 1'b0;
		endcase
		if (jump) begin
			step_next = uw.target;
		end else if (uw.last) begin
			step_next = dfc_pkg::STEP_FETCH;
		end else begin
			step_next = step_q + 1'b1;
		end
	end

	// Handshake outputs.
	always_comb begin
		sample_ready = (uw.op == dfc_pkg::OP_FETCH);
		cfg_ready    = 1'b1;
		result_valid = result_valid_q;
		result       = result_q;
	end

	// Clamp, divide by multiplying with the reciprocal, and threshold compare.
	always_comb begin
		if (in_q.range_cm > {{(dfc_pkg::DIST_W - dfc_pkg::CM_W){1'b0}}, clamp_q}) begin
			clamped = clamp_q;
		end else begin
			clamped = in_q.range_cm[dfc_pkg::CM_W-1:0];
		end
		product = {{(dfc_pkg::RECIP_W){1'b0}}, sum_q} *
			{{(dfc_pkg::SUM_W){1'b0}}, dfc_pkg::recip(dfc_pkg::RECIP_IN_W'(fill_q))};
		if (avg_q < stop_q) begin
			cmd_class = dfc_pkg::CMD_STOP;
		end else if (avg_q < decel_q) begin
			cmd_class = dfc_pkg::CMD_DECEL;
		end else if (avg_q < maintain_q) begin
			cmd_class = dfc_pkg::CMD_MAINTAIN;
		end else begin
			cmd_class = dfc_pkg::CMD_ACCEL;
		end
	end

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q     <= 10'd30;
			decel_q    <= 10'd80;
			maintain_q <= 10'd150;
			clamp_q    <= 10'd400;
			fault_q    <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dfc_pkg::REG_STOP:     stop_q     <= cfg_data;
				dfc_pkg::REG_DECEL:    decel_q    <= cfg_data;
				dfc_pkg::REG_MAINTAIN: maintain_q <= cfg_data;
				dfc_pkg::REG_CLAMP:    clamp_q    <= cfg_data;
				dfc_pkg::REG_FAULT:    fault_q    <= cfg_data[dfc_pkg::RUN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, filter state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q         <= dfc_pkg::STEP_FETCH;
			fill_q         <= '0;
			slot_q         <= '0;
			run_q          <= '0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < dfc_pkg::WINDOW; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			step_q <= step_next;
			// The output register fills at the emit step and empties when its word is taken.
			if (uw.op == dfc_pkg::OP_EMIT && has_result && !out_busy) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (uw.op)
				dfc_pkg::OP_UPDATE: begin
					if (in_q.timed_out) begin
						if (run_q != dfc_pkg::RUN_MAX) begin
							run_q <= run_q + 1'b1;
						end
					end else begin
						run_q          <= '0;
						ring_q[slot_q] <= clamped;
						if (slot_q == dfc_pkg::IDX_W'(dfc_pkg::WINDOW - 1)) begin
							slot_q <= '0;
						end else begin
							slot_q <= slot_q + 1'b1;
						end
						if (fill_q != dfc_pkg::FILL_W'(dfc_pkg::WINDOW)) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		case (uw.op)
			dfc_pkg::OP_FETCH: begin
				if (sample_valid) begin
					in_q <= sample;
				end
			end
			dfc_pkg::OP_UPDATE: begin
				sum_q     <= '0;
				acc_idx_q <= '0;
			end
			dfc_pkg::OP_ACC: begin
				sum_q     <= sum_q + {{(dfc_pkg::SUM_W - dfc_pkg::CM_W){1'b0}}, ring_q[acc_idx_q]};
				acc_idx_q <= acc_idx_q + 1'b1;
			end
			dfc_pkg::OP_DIV: begin
				avg_q <= product[dfc_pkg::DIV_SHIFT +: dfc_pkg::CM_W];
			end
			dfc_pkg::OP_EMIT: begin
				if (has_result && !out_busy) begin
					if (fault_now) begin
						result_q.command    <= dfc_pkg::CMD_FAULT;
						result_q.mean_cm    <= '0;
						result_q.fault_flag <= 1'b1;
					end else begin
						result_q.command    <= cmd_class;
						result_q.mean_cm    <= avg_q;
						result_q.fault_flag <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	// Checks on the sequencer and filter state.
	`DFC_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= dfc_pkg::FILL_W'(dfc_pkg::WINDOW))
	`DFC_ASSERT_NOW(a_slot_bound, 1'b1, slot_q < dfc_pkg::IDX_W'(dfc_pkg::WINDOW))
	`DFC_ASSERT_NEXT(a_accept_update, sample_valid && sample_ready, step_q == dfc_pkg::STEP_UPDATE)
	`DFC_ASSERT_NEXT(a_timeout_run, uw.op == dfc_pkg::OP_UPDATE && in_q.timed_out, run_q != '0)
	`DFC_ASSERT_NOW(a_fault_word, result_valid_q && result_q.fault_flag,
		result_q.command == dfc_pkg::CMD_FAULT && result_q.mean_cm == '0)

endmodule

### bench/tb_distance_filter_classifier.sv
`timescale 1ns / 1ps

module tb_distance_filter_classifier;

	// Spare register index: writes to it must leave every threshold untouched.
	localparam logic [dfc_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 500000;

	// Mirror of the classifier: configuration, sample ring and timeout run, plus the
	// command words still owed by the block.
	class command_board;
		logic [dfc_pkg::CM_W-1:0]  stop_lim;
		logic [dfc_pkg::CM_W-1:0]  decel_lim;
		logic [dfc_pkg::CM_W-1:0]  maint_lim;
		logic [dfc_pkg::CM_W-1:0]  clamp_lim;
		logic [dfc_pkg::RUN_W-1:0] fault_lim;
		logic [dfc_pkg::RUN_W-1:0] run;
		logic [dfc_pkg::CM_W-1:0]  ring [dfc_pkg::WINDOW];
		int                        fill;
		int                        slot;
		int                        errors;
		dfc_pkg::result_t          due_words[$];

		function new();
			stop_lim = 10'd30;
			decel_lim = 10'd80;
			maint_lim = 10'd150;
			clamp_lim = 10'd400;
			fault_lim = 8'd3;
			run = '0;
			foreach (ring[i]) ring[i] = '0;
			fill = 0;
			slot = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [dfc_pkg::CFG_IDX_W-1:0] idx,
				logic [dfc_pkg::CFG_DAT_W-1:0] val);
			case (idx)
				dfc_pkg::REG_STOP:     stop_lim = val;
				dfc_pkg::REG_DECEL:    decel_lim = val;
				dfc_pkg::REG_MAINTAIN: maint_lim = val;
				dfc_pkg::REG_CLAMP:    clamp_lim = val;
				dfc_pkg::REG_FAULT:    fault_lim = val[dfc_pkg::RUN_W-1:0];
				default:               ;
			endcase
		endfunction

		// Thresholds are tried in a fixed order, so unordered settings still give
		// the first one that the average falls below.
		function logic [dfc_pkg::CMD_W-1:0] grade(logic [dfc_pkg::CM_W-1:0] cm);
			if (cm < stop_lim) return dfc_pkg::CMD_STOP;
			if (cm < decel_lim) return dfc_pkg::CMD_DECEL;
			if (cm < maint_lim) return dfc_pkg::CMD_MAINTAIN;
			return dfc_pkg::CMD_ACCEL;
		endfunction

		function void note_sample(dfc_pkg::sample_t s);
			int                       total;
			int                       mean;
			int                       i;
			logic [dfc_pkg::CM_W-1:0] kept;
			dfc_pkg::result_t         w;
			mean = 0;
			if (s.timed_out) begin
				if (run != dfc_pkg::RUN_MAX) run = run + 1'b1;
			end else begin
				run = '0;
				if (s.range_cm > clamp_lim) kept = clamp_lim;
				else kept = s.range_cm[dfc_pkg::CM_W-1:0];
				ring[slot] = kept;
				slot = (slot + 1) % dfc_pkg::WINDOW;
				if (fill < dfc_pkg::WINDOW) fill++;
				total = 0;
				for (i = 0; i < fill; i++) total += ring[i];
				mean = total / fill;
			end
			// A zero threshold is met by every sample, valid ones included.
			if (run >= fault_lim) begin
				w.command = dfc_pkg::CMD_FAULT;
				w.mean_cm = '0;
				w.fault_flag = 1'b1;
				due_words.push_back(w);
			end else if (!s.timed_out) begin
				w.command = grade(mean[dfc_pkg::CM_W-1:0]);
				w.mean_cm = mean[dfc_pkg::CM_W-1:0];
				w.fault_flag = 1'b0;
				due_words.push_back(w);
			end
		endfunction

		function void check_word(dfc_pkg::result_t got);
			dfc_pkg::result_t want;
			if (due_words.size() == 0) begin
				$error("unexpected word: command %0d mean_cm %0d fault_flag %0d",
					got.command, got.mean_cm, got.fault_flag);
				errors++;
				return;
			end
			want = due_words.pop_front();
			if (got.command !== want.command) begin
				$error("command: expected %0d, got %0d", want.command, got.command);
				errors++;
			end
			if (got.mean_cm !== want.mean_cm) begin
				$error("mean_cm: expected %0d, got %0d", want.mean_cm, got.mean_cm);
				errors++;
			end
			if (got.fault_flag !== want.fault_flag) begin
				$error("fault_flag: expected %0d, got %0d", want.fault_flag,
					got.fault_flag);
				errors++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          sample_valid = 1'b0;
	logic                          sample_ready;
	dfc_pkg::sample_t              sample = '0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	dfc_pkg::result_t              result;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [dfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [dfc_pkg::CFG_DAT_W-1:0] cfg_data = '0;

	command_board board;
	bit           eager = 1'b0;
	int           cycle_count = 0;

	distance_filter_classifier uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Idle cycles before the next word; none at all during an eager stretch.
	function automatic int pick_gap();
		if (eager) return 0;
		return $urandom_range(0, 15);
	endfunction

	// Offers one sample word and returns at the edge that accepts it.
	task automatic send_sample(dfc_pkg::sample_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (sample_ready !== 1'b1);
		board.note_sample(s);
	endtask

	task automatic write_reg(logic [dfc_pkg::CFG_IDX_W-1:0] idx,
			logic [dfc_pkg::CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		board.write_reg(idx, val);
	endtask

	task automatic apply_settings(logic [dfc_pkg::CFG_DAT_W-1:0] stop_cm,
			logic [dfc_pkg::CFG_DAT_W-1:0] decel_cm, logic [dfc_pkg::CFG_DAT_W-1:0] maint_cm,
			logic [dfc_pkg::CFG_DAT_W-1:0] clamp_cm, logic [dfc_pkg::CFG_DAT_W-1:0] fault_n);
		write_reg(dfc_pkg::REG_STOP, stop_cm);
		write_reg(dfc_pkg::REG_DECEL, decel_cm);
		write_reg(dfc_pkg::REG_MAINTAIN, maint_cm);
		write_reg(dfc_pkg::REG_CLAMP, clamp_cm);
		write_reg(dfc_pkg::REG_FAULT, fault_n);
		write_reg(REG_SPARE, dfc_pkg::CFG_DAT_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// Holds the sample channel off until every owed word is back, then lets a
	// trailing timeout finish inside the block.
	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (board.due_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly valid distances aimed at the field, the clamp and the thresholds, with
	// bursts of timeouts about as long as the fault threshold.
	task automatic random_phase(int count);
		int                       sent;
		int                       burst;
		logic [dfc_pkg::CM_W-1:0] base;
		dfc_pkg::sample_t         s;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 19) == 0) eager = !eager;
			if ($urandom_range(0, 3) == 0) begin
				burst = $urandom_range(1, board.fault_lim + 2);
				repeat (burst) begin
					s.timed_out = 1'b1;
					s.range_cm = dfc_pkg::DIST_W'($urandom);
					send_sample(s);
					sent++;
				end
			end else begin
				s.timed_out = 1'b0;
				case ($urandom_range(0, 3))
					0: s.range_cm = dfc_pkg::DIST_W'($urandom);
					1: s.range_cm = dfc_pkg::DIST_W'($urandom_range(0, 1023));
					2: begin
						case ($urandom_range(0, 2))
							0:       base = board.stop_lim;
							1:       base = board.decel_lim;
							default: base = board.maint_lim;
						endcase
						s.range_cm = dfc_pkg::DIST_W'(base + $urandom_range(0, 4) - 2);
					end
					default: begin
						s.range_cm = dfc_pkg::DIST_W'(board.clamp_lim +
							$urandom_range(0, 3) - 1);
					end
				endcase
				send_sample(s);
				sent++;
			end
		end
	endtask

	// Result side: random stalls before each word, checked at acceptance.
	initial begin : take_results
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (result_valid !== 1'b1);
			board.check_word(result);
		end
	end

	// Watchdog on the whole run.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int               a;
		int               b;
		int               c;
		dfc_pkg::sample_t word;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: field extremes, clamp, threshold edges and a fault run.
		send_sample({1'b0, 16'd0});
		send_sample({1'b0, 16'hFFFF});
		send_sample({1'b0, 16'h8000});
		send_sample({1'b0, 16'd90});
		send_sample({1'b0, 16'd29});
		send_sample({1'b0, 16'd29});
		send_sample({1'b0, 16'd29});
		send_sample({1'b0, 16'd30});
		send_sample({1'b0, 16'd30});
		send_sample({1'b0, 16'd30});
		send_sample({1'b0, 16'd80});
		send_sample({1'b0, 16'd80});
		send_sample({1'b0, 16'd80});
		send_sample({1'b0, 16'd149});
		send_sample({1'b0, 16'd150});
		send_sample({1'b0, 16'd151});
		send_sample({1'b1, 16'hFFFF});
		send_sample({1'b1, 16'd0});
		send_sample({1'b1, 16'h1234});
		send_sample({1'b1, 16'h5555});
		send_sample({1'b0, 16'd400});
		send_sample({1'b0, 16'd401});
		send_sample({1'b0, 16'h03FF});
		wait_idle();

		// All zero: everything clamps to zero and a single timeout is a fault.
		apply_settings(10'd0, 10'd0, 10'd0, 10'd0, 10'd1);
		random_phase(30);
		wait_idle();

		// All ones; the fault threshold takes only its low eight bits. A long
		// timeout run must hold the count at its ceiling rather than wrap.
		apply_settings(10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF);
		send_sample({1'b0, 16'hFFFF});
		send_sample({1'b0, 16'd500});
		repeat (260) begin
			word.timed_out = 1'b1;
			word.range_cm = dfc_pkg::DIST_W'($urandom);
			send_sample(word);
		end
		send_sample({1'b0, 16'd1023});
		wait_idle();

		// Thresholds out of order.
		apply_settings(10'd500, 10'd100, 10'd300, 10'd700, 10'd5);
		random_phase(60);
		wait_idle();

		// Fault threshold of zero after masking: every word is a fault.
		apply_settings(10'd40, 10'd200, 10'd600, 10'd900, 10'h100);
		random_phase(30);
		wait_idle();

		// Random ascending settings.
		repeat (6) begin
			a = $urandom_range(0, 400);
			b = a + $urandom_range(0, 300);
			c = b + $urandom_range(0, 300);
			apply_settings(dfc_pkg::CFG_DAT_W'(a), dfc_pkg::CFG_DAT_W'(b),
				dfc_pkg::CFG_DAT_W'(c), dfc_pkg::CFG_DAT_W'($urandom_range(100, 1023)),
				dfc_pkg::CFG_DAT_W'($urandom_range(1, 8)));
			random_phase(35);
			wait_idle();
		end

		if (board.errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/dfc_pkg.sv
rtl/distance_filter_classifier.sv
bench/tb_distance_filter_classifier.sv
